// ----- hdl/hlfr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hlfr_pkg
// Shared types and constants of the header/length frame receiver.
// ----------------------------------------------------------------------------
package hlfr_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'hAF;
    localparam logic [7:0] FUNC_END   = 8'hF1;

    localparam int FRAME_EXTRA       = 5;
    localparam int PAYLOAD_LIMIT_DEF = 50;
    localparam int STORE_DEPTH_DEF   = 64;

    localparam int IDX_W = 6;
    localparam int CNT_W = IDX_W + 1;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_HDR2    = 3'd2,
        PH_FUNC    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } hlfr_phase_t;

    typedef enum logic [1:0] {
        DUMP_IDLE = 2'd0,
        DUMP_LOAD = 2'd1,
        DUMP_HOLD = 2'd2
    } hlfr_dump_state_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } hlfr_wr_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] len;
    } hlfr_dump_req_t;

endpackage : hlfr_pkg
`default_nettype wire

// ----- hdl/hlfr_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hlfr_store
// Frame byte memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hlfr_store
    import hlfr_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    localparam int AW = $clog2(STORE_DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [7:0]         rd_data
);

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : hlfr_store
`default_nettype wire

// ----- hdl/hlfr_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hlfr_parser
// Header, function and length parser; writes accepted bytes to the store
// and raises a dump request on the trailing byte.
// ----------------------------------------------------------------------------
module hlfr_parser
    import hlfr_pkg::*;
#(
    parameter int PAYLOAD_LIMIT = PAYLOAD_LIMIT_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] rx_byte,
    output hlfr_wr_t        wr,
    output hlfr_dump_req_t  dump_req
);

    hlfr_phase_t      phase_reg, phase_next;
    logic [IDX_W-1:0] left_reg, left_next;
    logic [IDX_W-1:0] count_reg, count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            left_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        left_next      = left_reg;
        count_next     = count_reg;
        wr.en          = 1'b0;
        wr.addr        = '0;
        wr.data        = rx_byte;
        dump_req.start = 1'b0;
        dump_req.len   = CNT_W'({1'b0, count_reg}) + CNT_W'(FRAME_EXTRA);
        if (accept)
        begin
            phase_next = PH_IDLE;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (rx_byte == HDR_FIRST)
                    begin
                        phase_next = PH_HDR1;
                        wr.en      = 1'b1;
                        wr.addr    = IDX_W'(0);
                    end
                end
                PH_HDR1:
                begin
                    if (rx_byte == HDR_SECOND)
                    begin
                        phase_next = PH_HDR2;
                        wr.en      = 1'b1;
                        wr.addr    = IDX_W'(1);
                    end
                end
                PH_HDR2:
                begin
                    if (rx_byte != 8'd0 && rx_byte < FUNC_END)
                    begin
                        phase_next = PH_FUNC;
                        wr.en      = 1'b1;
                        wr.addr    = IDX_W'(2);
                    end
                end
                PH_FUNC:
                begin
                    if (rx_byte < 8'(PAYLOAD_LIMIT))
                    begin
                        phase_next = PH_PAYLOAD;
                        wr.en      = 1'b1;
                        wr.addr    = IDX_W'(3);
                        left_next  = rx_byte[IDX_W-1:0];
                        count_next = '0;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (left_reg != '0)
                    begin
                        wr.en      = 1'b1;
                        wr.addr    = count_reg + IDX_W'(4);
                        left_next  = left_reg - IDX_W'(1);
                        count_next = count_reg + IDX_W'(1);
                        phase_next = (left_reg == IDX_W'(1)) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
                PH_CHECK:
                begin
                    wr.en          = 1'b1;
                    wr.addr        = count_reg + IDX_W'(4);
                    dump_req.start = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

endmodule : hlfr_parser
`default_nettype wire

// ----- hdl/hlfr_dump.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hlfr_dump
// Frame dump sequencer: reads the store one byte at a time and presents
// each byte with its index, length and last marker in an output register.
// ----------------------------------------------------------------------------
module hlfr_dump
    import hlfr_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire hlfr_dump_req_t  dump_req,
    output logic                 rd_en,
    output logic [IDX_W-1:0]     rd_addr,
    input  wire logic [7:0]      rd_data,
    output logic                 busy,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [7:0]           out_byte,
    output logic [IDX_W-1:0]     out_index,
    output logic [IDX_W-1:0]     out_length,
    output logic                 out_last
);

    hlfr_dump_state_t state_reg, state_next;
    logic             valid_reg, valid_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last;

    assign last = (idx_reg + CNT_W'(1)) == len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DUMP_IDLE;
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        byte_next  = byte_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg[IDX_W-1:0];
        case (state_reg)
            DUMP_IDLE:
            begin
                if (dump_req.start)
                begin
                    idx_next   = '0;
                    len_next   = dump_req.len;
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = DUMP_LOAD;
                end
            end
            DUMP_LOAD:
            begin
                byte_next  = rd_data;
                valid_next = 1'b1;
                state_next = DUMP_HOLD;
            end
            DUMP_HOLD:
            begin
                if (out_ready)
                begin
                    valid_next = 1'b0;
                    if (last)
                    begin
                        state_next = DUMP_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        rd_en      = 1'b1;
                        rd_addr    = idx_next[IDX_W-1:0];
                        state_next = DUMP_LOAD;
                    end
                end
            end
            default:
            begin
                valid_next = 1'b0;
                state_next = DUMP_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg != DUMP_IDLE);
    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign out_index  = idx_reg[IDX_W-1:0];
    assign out_length = len_reg[IDX_W-1:0];
    assign out_last   = last;

`ifndef SYNTHESIS
    a_start_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        dump_req.start |-> state_reg == DUMP_IDLE)
        else $error("dump request while a frame is being emitted");

    a_valid_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg == (state_reg == DUMP_HOLD))
        else $error("output valid out of step with the sequencer");

    a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> idx_reg < len_reg && len_reg >= CNT_W'(FRAME_EXTRA))
        else $error("dump index outside the frame");

    a_last_ends_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_ready && last) |=> state_reg == DUMP_IDLE)
        else $error("dump did not end after the last byte");
`endif

endmodule : hlfr_dump
`default_nettype wire

// ----- hdl/header_length_frame_receiver.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// header_length_frame_receiver
// Parses AA AF / function / length / payload / check frames from a byte
// stream and emits each completed frame byte by byte.
//
// Input: one received byte per request on s_axis (tdata = rx_byte).
// Output: one frame byte per request on m_axis; tdata carries frame_byte,
// byte_index and frame_length, tlast marks the final byte of the frame.
// While parsing, the block takes one byte per cycle. Only the trailing
// check byte produces output: taking it starts a store read of the first
// frame byte, and taking each frame byte starts the read of the next one;
// each read goes through the store read register and then the output
// register, and no frame byte is read before the previous one is taken.
// s_axis_tready stays low while a frame is emitted, also while the
// receiver holds m_axis_tready low; the output byte is held stable while
// stalled. Bad bytes are dropped and restart the search for the first
// header byte.
// Reset returns the parser to idle and drops any frame being emitted; the
// frame store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module header_length_frame_receiver
    import hlfr_pkg::*;
#(
    parameter int PAYLOAD_LIMIT = PAYLOAD_LIMIT_DEF,
    parameter int STORE_DEPTH   = STORE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [7:0] frame_byte, [13:8] byte_index,
                                             // [19:14] frame_length, [23:20] zero
    output logic             m_axis_tlast    // is_last
);

    localparam int AW = $clog2(STORE_DEPTH);

    hlfr_wr_t         wr;
    hlfr_dump_req_t   dump_req;
    logic             accept;
    logic             busy;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data;
    logic [7:0]       out_byte;
    logic [IDX_W-1:0] out_index;
    logic [IDX_W-1:0] out_length;

    assign s_axis_tready = !busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    hlfr_parser #(
        .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rx_byte  (s_axis_tdata),
        .wr       (wr),
        .dump_req (dump_req)
    );

    hlfr_store #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (AW'(wr.addr)),
        .wr_data (wr.data),
        .rd_en   (rd_en),
        .rd_addr (AW'(rd_addr)),
        .rd_data (rd_data)
    );

    hlfr_dump u_dump (
        .clk        (clk),
        .rst_n      (rst_n),
        .dump_req   (dump_req),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .busy       (busy),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (out_byte),
        .out_index  (out_index),
        .out_length (out_length),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, out_length, out_index, out_byte};

endmodule : header_length_frame_receiver
`default_nettype wire

// ----- verif/tb_header_length_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// tb_header_length_frame_receiver
// Self-checking bench for the AA AF / function / length / payload / check
// frame receiver. Bytes go in on s_axis with random gaps. A local parser
// predicts every frame byte that must come out on m_axis, and each output
// request is compared field by field while the sink stalls at random.
// ----------------------------------------------------------------------------
module tb_header_length_frame_receiver;
    import hlfr_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int DRAIN_TAIL  = 16;
    localparam int RANDOM_BYTES = 80;

    typedef struct packed {
        logic [7:0] fbyte;
        logic [5:0] idx;
        logic [5:0] flen;
        logic       last;
    } frame_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    hlfr_phase_t rx_phase = PH_IDLE;
    logic [5:0]  rx_bytes_left = '0;
    logic [5:0]  rx_payload_cnt = '0;
    logic [7:0]  frame_mem [STORE_DEPTH_DEF];

    frame_beat_t frame_beats_q [$];
    int          errors = 0;
    bit          sender_gaps_on = 1'b1;
    bit          sink_stalls_on = 1'b1;

    header_length_frame_receiver i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    // advance the frame parser by one received byte; queue any frame it completes
    function automatic void parse_rx_byte(input logic [7:0] b);
        frame_beat_t beat;
        int          flen;
        if (rx_phase == PH_IDLE && b == HDR_FIRST)
        begin
            rx_phase = PH_HDR1;
            frame_mem[0] = b;
        end
        else if (rx_phase == PH_HDR1 && b == HDR_SECOND)
        begin
            rx_phase = PH_HDR2;
            frame_mem[1] = b;
        end
        else if (rx_phase == PH_HDR2 && b != 8'h00 && b < FUNC_END)
        begin
            rx_phase = PH_FUNC;
            frame_mem[2] = b;
        end
        else if (rx_phase == PH_FUNC && int'(b) < PAYLOAD_LIMIT_DEF)
        begin
            rx_phase = PH_PAYLOAD;
            frame_mem[3] = b;
            rx_bytes_left = b[5:0];
            rx_payload_cnt = '0;
        end
        else if (rx_phase == PH_PAYLOAD && rx_bytes_left != 0)
        begin
            rx_bytes_left = rx_bytes_left - 6'd1;
            frame_mem[6'(4 + rx_payload_cnt)] = b;
            rx_payload_cnt = rx_payload_cnt + 6'd1;
            if (rx_bytes_left == 0)
            begin
                rx_phase = PH_CHECK;
            end
        end
        else if (rx_phase == PH_CHECK)
        begin
            rx_phase = PH_IDLE;
            frame_mem[6'(4 + rx_payload_cnt)] = b;
            flen = int'(rx_payload_cnt) + FRAME_EXTRA;
            for (int i = 0; i < flen; i++)
            begin
                beat.fbyte = frame_mem[i % STORE_DEPTH_DEF];
                beat.idx   = 6'(i);
                beat.flen  = 6'(flen);
                beat.last  = (i + 1 == flen);
                frame_beats_q.push_back(beat);
            end
        end
        else
        begin
            rx_phase = PH_IDLE;
        end
    endfunction

    // check output requests against the oldest expectation, then predict input
    always @(posedge clk)
    begin
        frame_beat_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (frame_beats_q.size() == 0)
                begin
                    report_mismatch("output with none expected, tdata",
                                    int'(m_axis_tdata), 0);
                end
                else
                begin
                    want = frame_beats_q.pop_front();
                    if (m_axis_tdata[7:0] !== want.fbyte)
                        report_mismatch("frame_byte", int'(m_axis_tdata[7:0]),
                                        int'(want.fbyte));
                    if (m_axis_tdata[13:8] !== want.idx)
                        report_mismatch("byte_index", int'(m_axis_tdata[13:8]),
                                        int'(want.idx));
                    if (m_axis_tdata[19:14] !== want.flen)
                        report_mismatch("frame_length", int'(m_axis_tdata[19:14]),
                                        int'(want.flen));
                    if (m_axis_tlast !== want.last)
                        report_mismatch("tlast", int'(m_axis_tlast), int'(want.last));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                parse_rx_byte(s_axis_tdata);
            end
        end
    end

    // sink: stall a random number of cycles before each output request
    initial
    begin
        int stall;
        forever
        begin
            stall = sink_stalls_on ? $urandom_range(0, 6) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_header_length_frame_receiver: FAIL");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = sender_gaps_on ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // hold input until every queued frame byte has come out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (frame_beats_q.size() != 0) @(posedge clk);
    endtask

    // break_at 1..3 replaces that header position with a byte it must reject
    task automatic send_frame(input logic [7:0] func, input int len, input int break_at);
        logic [7:0] bad;
        send_byte(HDR_FIRST);
        if (break_at == 1)
        begin
            do bad = 8'($urandom_range(0, 255)); while (bad == HDR_SECOND);
            send_byte(bad);
            return;
        end
        send_byte(HDR_SECOND);
        if (break_at == 2)
        begin
            bad = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(int'(FUNC_END), 255));
            send_byte(bad);
            return;
        end
        send_byte(func);
        if (break_at == 3)
        begin
            send_byte(8'($urandom_range(PAYLOAD_LIMIT_DEF, 255)));
            return;
        end
        send_byte(8'(len));
        repeat (len) send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic test_directed();
        // shortest frame, lowest function code, one zero payload byte, all-ones check
        send_byte(HDR_FIRST); send_byte(HDR_SECOND); send_byte(8'h01);
        send_byte(8'h01); send_byte(8'h00); send_byte(8'hFF);
        // zero length: the next byte aborts, a header byte included
        send_byte(HDR_FIRST); send_byte(HDR_SECOND); send_byte(8'hF0);
        send_byte(8'h00); send_byte(HDR_FIRST);
        // function code zero and first code past the range
        send_byte(HDR_FIRST); send_byte(HDR_SECOND); send_byte(8'h00);
        send_byte(HDR_FIRST); send_byte(HDR_SECOND); send_byte(FUNC_END);
        // length at the limit
        send_byte(HDR_FIRST); send_byte(HDR_SECOND); send_byte(8'h05);
        send_byte(8'(PAYLOAD_LIMIT_DEF));
        // repeated first header byte is dropped, not rechecked
        send_byte(HDR_FIRST); send_byte(HDR_FIRST); send_byte(HDR_SECOND);
    endtask

    task automatic test_longest_frame();
        send_frame(8'hF0, PAYLOAD_LIMIT_DEF - 1, 0);
    endtask

    task automatic test_random_frames();
        int  sent;
        int  kind;
        int  len;
        bit  paused;
        sent = 0;
        paused = 1'b0;
        while (sent < RANDOM_BYTES)
        begin
            sender_gaps_on = !(sent >= 25 && sent < 45);
            sink_stalls_on = !(sent >= 20 && sent < 40);
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 15) == 0)
                len = 0;
            else if ($urandom_range(0, 11) == 0)
                len = $urandom_range(10, PAYLOAD_LIMIT_DEF - 1);
            else
                len = $urandom_range(1, 6);
            if (kind < 7)
            begin
                send_frame(8'($urandom_range(1, int'(FUNC_END) - 1)), len, 0);
                sent += len + FRAME_EXTRA;
            end
            else if (kind < 9)
            begin
                send_frame(8'($urandom_range(1, int'(FUNC_END) - 1)), len,
                           $urandom_range(1, 3));
            end
            else
            begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end
            if (!paused && sent >= 50)
            begin
                drain_results();
                paused = 1'b1;
            end
        end
        sender_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_longest_frame();
        test_random_frames();
        drain_results();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (errors == 0)
            $display("tb_header_length_frame_receiver: PASS");
        else
            $display("tb_header_length_frame_receiver: FAIL");
        $finish;
    end

endmodule
